[rtl/assert_macros.svh]
// Assertion macros shared by the log record stream checker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LRSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define LRSC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/lrsc_pkg.sv]
// Types and constants of the log record stream checker
package lrsc_pkg;

  localparam logic [31:0] LOG_MAGIC   = 32'h3156_4B53;
  localparam logic [15:0] LOG_VERSION = 16'd1;
  localparam logic [31:0] HASH_BASIS  = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME  = 32'd16777619;
  localparam logic [4:0]  HDR_LAST    = 5'd27;
  localparam logic [63:0] SEQ_START   = 64'd1;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MAGIC   = 3'd1;
  localparam logic [2:0] ST_SIZE    = 3'd2;
  localparam logic [2:0] ST_ORDER   = 3'd3;
  localparam logic [2:0] ST_TYPE    = 3'd4;
  localparam logic [2:0] ST_CSUM    = 3'd5;
  localparam logic [2:0] ST_PARTIAL = 3'd6;

  localparam logic [1:0] CFG_MAX_KEY   = 2'd0;
  localparam logic [1:0] CFG_MAX_VALUE = 2'd1;
  localparam logic [1:0] CFG_PUT_CODE  = 2'd2;
  localparam logic [1:0] CFG_ERASE_CODE = 2'd3;

  localparam logic [31:0] MAX_KEY_RST   = 32'd1024;
  localparam logic [31:0] MAX_VALUE_RST = 32'd65536;
  localparam logic [7:0]  PUT_CODE_RST  = 8'd0;
  localparam logic [7:0]  ERASE_CODE_RST = 8'd1;

  typedef struct packed {
    logic [7:0] log_byte;
    logic       first_byte;
    logic       end_of_log;
    logic       empty_log;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        in_value;
    logic        is_erase;
    logic [63:0] sequence_res;
    logic [31:0] key_len;
    logic [31:0] value_len;
    logic [2:0]  status;
    logic [63:0] next_sequence;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       res;
  } push_t;

endpackage

[rtl/lrsc_if.sv]
// Valid/ready channel interfaces for log words and result words
interface lrsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] log_byte;
  logic       first_byte;
  logic       end_of_log;
  logic       empty_log;

  modport source (output valid, log_byte, first_byte, end_of_log, empty_log, input ready);
  modport sink (input valid, log_byte, first_byte, end_of_log, empty_log, output ready);
endinterface

interface lrsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        in_value;
  logic        is_erase;
  logic [63:0] sequence_res;
  logic [31:0] key_len;
  logic [31:0] value_len;
  logic [2:0]  status;
  logic [63:0] next_sequence;
  logic        last;

  modport source (output valid, kind, data_byte, in_value, is_erase, sequence_res,
                  key_len, value_len, status, next_sequence, last, input ready);
  modport sink (input valid, kind, data_byte, in_value, is_erase, sequence_res,
                key_len, value_len, status, next_sequence, last, output ready);
endinterface

[rtl/log_record_stream_checker.sv]
// Log record stream checker top level: parser core and result queue
//
//   channel  dir  handshake          word
//   in_ch    in   valid/ready        log_byte, first_byte, end_of_log, empty_log
//   out_ch   out  valid/ready        kind .. last (zero to three results per word)
//   cfg_*    in   write enable only  cfg_idx, cfg_data
//
// One input word per cycle while each word yields at most one result and out_ch is
// ready; each of a word's results (up to three) uses the single result read port.
// Path to a first result: the input register, then the result queue.
// Reset is synchronous; it clears parse state and restores register defaults.
// A stalled output fills the result queue, then in_ch.ready drops.
module log_record_stream_checker #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  lrsc_in_if.sink     in_ch,
  lrsc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  lrsc_pkg::in_word_t in_word;
  lrsc_pkg::push_t    push;
  lrsc_pkg::res_t     res;
  logic               room;

  assign in_word.log_byte   = in_ch.log_byte;
  assign in_word.first_byte = in_ch.first_byte;
  assign in_word.end_of_log = in_ch.end_of_log;
  assign in_word.empty_log  = in_ch.empty_log;

  lrsc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_word  (in_word),
    .room_i   (room),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .push_o   (push)
  );

  lrsc_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .room_o    (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.kind          = res.kind;
  assign out_ch.data_byte     = res.data_byte;
  assign out_ch.in_value      = res.in_value;
  assign out_ch.is_erase      = res.is_erase;
  assign out_ch.sequence_res  = res.sequence_res;
  assign out_ch.key_len       = res.key_len;
  assign out_ch.value_len     = res.value_len;
  assign out_ch.status        = res.status;
  assign out_ch.next_sequence = res.next_sequence;
  assign out_ch.last          = res.last;

endmodule

[rtl/lrsc_core.sv]
// Input register, record parser state and per-word result generation
`include "assert_macros.svh"

module lrsc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrsc_pkg::in_word_t in_word,
  input  logic              room_i,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_data,
  output lrsc_pkg::push_t   push_o
);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_KEY = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  logic [31:0] max_key_r, max_val_r;
  logic [7:0]  put_code_r, erase_code_r;

  logic              stg_valid_r;
  lrsc_pkg::in_word_t stg_r;
  logic              go;

  logic [1:0]        phase_r, phase_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [3:0][63:0]  hdr_r, hdr_nxt;
  logic [31:0]       rk_r, rk_nxt, rv_r, rv_nxt;
  logic [31:0]       hash_r, hash_nxt;
  logic [63:0]       last_seq_r, last_seq_nxt;
  logic [63:0]       foll_r, foll_nxt;
  logic              halted_r, halted_nxt;
  logic [2:0]        sticky_r, sticky_nxt;
  logic [1:0]        nres;
  lrsc_pkg::res_t [2:0] res_v;

  function automatic lrsc_pkg::res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                            input logic inval, input logic [2:0] st,
                                            input logic [3:0][63:0] hdr,
                                            input logic [63:0] foll,
                                            input logic [7:0] putc, input logic [7:0] erc);
    lrsc_pkg::res_t r;
    logic           rec;
    logic [7:0]     typ;
    rec = (kind != lrsc_pkg::KIND_END);
    typ = hdr[0][55:48];
    r.kind          = kind;
    r.data_byte     = data;
    r.in_value      = inval;
    r.is_erase      = rec && (typ != putc) && (typ == erc);
    r.sequence_res  = rec ? hdr[1] : 64'd0;
    r.key_len       = rec ? hdr[2][31:0] : 32'd0;
    r.value_len     = rec ? hdr[2][63:32] : 32'd0;
    r.status        = st;
    r.next_sequence = foll;
    r.last          = 1'b0;
    return r;
  endfunction

  assign go       = stg_valid_r && room_i;
  assign in_ready = !stg_valid_r || go;

  always_comb begin
    logic       fin;
    logic [2:0] code;
    logic [2:0] st;
    logic [31:0] hash_f;
    fin    = 1'b0;
    code   = lrsc_pkg::ST_OK;
    st     = lrsc_pkg::ST_OK;
    hash_f = hash_r;
    nres   = 2'd0;
    res_v  = '0;
    if (stg_r.first_byte) begin
      phase_nxt    = PH_HDR;
      cnt_nxt      = '0;
      hdr_nxt      = '0;
      rk_nxt       = '0;
      rv_nxt       = '0;
      hash_nxt     = lrsc_pkg::HASH_BASIS;
      last_seq_nxt = '0;
      foll_nxt     = lrsc_pkg::SEQ_START;
      halted_nxt   = 1'b0;
      sticky_nxt   = lrsc_pkg::ST_OK;
    end else begin
      phase_nxt    = phase_r;
      cnt_nxt      = cnt_r;
      hdr_nxt      = hdr_r;
      rk_nxt       = rk_r;
      rv_nxt       = rv_r;
      hash_nxt     = hash_r;
      last_seq_nxt = last_seq_r;
      foll_nxt     = foll_r;
      halted_nxt   = halted_r;
      sticky_nxt   = sticky_r;
    end

    if (!stg_r.empty_log && !halted_nxt) begin
      if (phase_nxt == PH_HDR) begin
        hdr_nxt[cnt_nxt[4:3]][{cnt_nxt[2:0], 3'b000} +: 8] = stg_r.log_byte;
        if (cnt_nxt >= lrsc_pkg::HDR_LAST) begin
          cnt_nxt = '0;
          if (hdr_nxt[0][31:0] != lrsc_pkg::LOG_MAGIC ||
              hdr_nxt[0][47:32] != lrsc_pkg::LOG_VERSION) begin
            code = lrsc_pkg::ST_MAGIC;
          end else if (hdr_nxt[2][31:0] > max_key_r || hdr_nxt[2][63:32] > max_val_r) begin
            code = lrsc_pkg::ST_SIZE;
          end else if (hdr_nxt[1] <= last_seq_nxt) begin
            code = lrsc_pkg::ST_ORDER;
          end else if (hdr_nxt[0][55:48] != put_code_r &&
                       hdr_nxt[0][55:48] != erase_code_r) begin
            code = lrsc_pkg::ST_TYPE;
          end
          if (code != lrsc_pkg::ST_OK) begin
            halted_nxt  = 1'b1;
            sticky_nxt  = code;
            res_v[nres] = mk_res(lrsc_pkg::KIND_VERDICT, 8'd0, 1'b0, code, hdr_nxt,
                                 foll_nxt, put_code_r, erase_code_r);
            nres        = nres + 2'd1;
          end else begin
            rk_nxt   = hdr_nxt[2][31:0];
            rv_nxt   = hdr_nxt[2][63:32];
            hash_nxt = lrsc_pkg::HASH_BASIS;
            if (rk_nxt != 32'd0) begin
              phase_nxt = PH_KEY;
            end else if (rv_nxt != 32'd0) begin
              phase_nxt = PH_VAL;
            end else begin
              fin    = 1'b1;
              hash_f = lrsc_pkg::HASH_BASIS;
            end
          end
        end else begin
          cnt_nxt = cnt_nxt + 5'd1;
        end
      end else begin
        hash_nxt    = (hash_nxt ^ {24'd0, stg_r.log_byte}) * lrsc_pkg::HASH_PRIME;
        hash_f      = hash_nxt;
        res_v[nres] = mk_res(lrsc_pkg::KIND_DATA, stg_r.log_byte, phase_nxt == PH_VAL,
                             lrsc_pkg::ST_OK, hdr_nxt, foll_nxt, put_code_r, erase_code_r);
        nres        = nres + 2'd1;
        if (phase_nxt == PH_KEY) begin
          rk_nxt = rk_nxt - 32'd1;
          if (rk_nxt == 32'd0) begin
            if (rv_nxt != 32'd0) begin
              phase_nxt = PH_VAL;
            end else begin
              fin = 1'b1;
            end
          end
        end else begin
          rv_nxt = rv_nxt - 32'd1;
          if (rv_nxt == 32'd0) begin
            fin = 1'b1;
          end
        end
      end

      if (fin) begin
        phase_nxt = PH_HDR;
        cnt_nxt   = '0;
        if (hash_f != hdr_nxt[3][31:0]) begin
          halted_nxt = 1'b1;
          sticky_nxt = lrsc_pkg::ST_CSUM;
          code       = lrsc_pkg::ST_CSUM;
        end else begin
          last_seq_nxt = hdr_nxt[1];
          foll_nxt     = hdr_nxt[1] + 64'd1;
          code         = lrsc_pkg::ST_OK;
        end
        res_v[nres] = mk_res(lrsc_pkg::KIND_VERDICT, 8'd0, 1'b0, code, hdr_nxt,
                             foll_nxt, put_code_r, erase_code_r);
        nres        = nres + 2'd1;
      end
    end

    if (stg_r.empty_log || stg_r.end_of_log) begin
      if (halted_nxt) begin
        st = sticky_nxt;
      end else if (phase_nxt == PH_HDR && cnt_nxt == 5'd0) begin
        st = lrsc_pkg::ST_OK;
      end else begin
        st = lrsc_pkg::ST_PARTIAL;
      end
      res_v[nres] = mk_res(lrsc_pkg::KIND_END, 8'd0, 1'b0, st, hdr_nxt, foll_nxt,
                           put_code_r, erase_code_r);
      nres        = nres + 2'd1;
    end

    if (nres != 2'd0) begin
      res_v[nres - 2'd1].last = 1'b1;
    end
  end

  assign push_o.cnt = go ? nres : 2'd0;
  assign push_o.res = res_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_r    <= lrsc_pkg::MAX_KEY_RST;
      max_val_r    <= lrsc_pkg::MAX_VALUE_RST;
      put_code_r   <= lrsc_pkg::PUT_CODE_RST;
      erase_code_r <= lrsc_pkg::ERASE_CODE_RST;
      stg_valid_r  <= 1'b0;
      phase_r      <= PH_HDR;
      cnt_r        <= '0;
      hdr_r        <= '0;
      rk_r         <= '0;
      rv_r         <= '0;
      hash_r       <= lrsc_pkg::HASH_BASIS;
      last_seq_r   <= '0;
      foll_r       <= lrsc_pkg::SEQ_START;
      halted_r     <= 1'b0;
      sticky_r     <= lrsc_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          lrsc_pkg::CFG_MAX_KEY:    max_key_r    <= cfg_data;
          lrsc_pkg::CFG_MAX_VALUE:  max_val_r    <= cfg_data;
          lrsc_pkg::CFG_PUT_CODE:   put_code_r   <= cfg_data[7:0];
          lrsc_pkg::CFG_ERASE_CODE: erase_code_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        stg_valid_r <= 1'b1;
      end else if (go) begin
        stg_valid_r <= 1'b0;
      end
      if (go) begin
        phase_r    <= phase_nxt;
        cnt_r      <= cnt_nxt;
        hdr_r      <= hdr_nxt;
        rk_r       <= rk_nxt;
        rv_r       <= rv_nxt;
        hash_r     <= hash_nxt;
        last_seq_r <= last_seq_nxt;
        foll_r     <= foll_nxt;
        halted_r   <= halted_nxt;
        sticky_r   <= sticky_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r <= in_word;
    end
  end

  `LRSC_ASSERT(a_end_is_last, go && (stg_r.empty_log || stg_r.end_of_log) |-> push_o.cnt != 2'd0 && push_o.res[push_o.cnt - 2'd1].kind == lrsc_pkg::KIND_END, "end word missing from result")
  `LRSC_ASSERT(a_three_last, go && push_o.cnt == 2'd3 |-> push_o.res[2].last && !push_o.res[1].last && !push_o.res[0].last, "last flag misplaced")
  `LRSC_ASSERT(a_halted_quiet, go && halted_r && !stg_r.first_byte && !stg_r.empty_log && !stg_r.end_of_log |-> push_o.cnt == 2'd0, "result emitted while halted")

endmodule

[rtl/lrsc_res_fifo.sv]
// Result queue: up to three words written per cycle, one read per cycle
`include "assert_macros.svh"

module lrsc_res_fifo #(
  parameter int DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lrsc_pkg::push_t push_i,
  output logic            room_o,
  output logic            out_valid,
  input  logic            out_ready,
  output lrsc_pkg::res_t  out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lrsc_pkg::res_t mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign room_o    = (cnt_r <= CW'(DEPTH - 3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push_i.cnt);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + CW'(push_i.cnt) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_r[wp_r + AW'(i)] <= push_i.res[i];
      end
    end
  end

  `LRSC_NEVER(a_no_overflow, int'(cnt_r) + int'(push_i.cnt) > DEPTH, "result queue overflow")

endmodule

[bench/tb_log_record_stream_checker.sv]
// Testbench of the log record stream checker: directed logs, random pacing, field checks
module tb_log_record_stream_checker;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;

  typedef enum logic [1:0] {IN_HEADER, IN_KEY, IN_VALUE} parse_phase_t;
  typedef enum int {END_ON_LAST, END_SEPARATE} log_end_t;

  class record_scoreboard;
    logic [31:0]    max_key;
    logic [31:0]    max_value;
    logic [7:0]     put_c;
    logic [7:0]     erase_c;
    parse_phase_t   phase;
    logic [4:0]     bcount;
    logic [63:0]    hdr [4];
    logic [31:0]    key_left;
    logic [31:0]    value_left;
    logic [31:0]    hash;
    logic [63:0]    seen_seq;
    logic [63:0]    follow_seq;
    bit             halted;
    logic [2:0]     sticky;
    lrsc_pkg::res_t expected_q[$];
    lrsc_pkg::res_t word_res[$];
    int             checked;
    int             verdicts;
    int             bad_verdicts;
    int             mismatches;

    function new();
      max_key = lrsc_pkg::MAX_KEY_RST;
      max_value = lrsc_pkg::MAX_VALUE_RST;
      put_c = lrsc_pkg::PUT_CODE_RST;
      erase_c = lrsc_pkg::ERASE_CODE_RST;
      restart_parse();
    endfunction

    function void restart_parse();
      phase = IN_HEADER;
      bcount = '0;
      foreach (hdr[i]) hdr[i] = '0;
      key_left = '0;
      value_left = '0;
      hash = lrsc_pkg::HASH_BASIS;
      seen_seq = '0;
      follow_seq = lrsc_pkg::SEQ_START;
      halted = 1'b0;
      sticky = lrsc_pkg::ST_OK;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        lrsc_pkg::CFG_MAX_KEY:    max_key = value;
        lrsc_pkg::CFG_MAX_VALUE:  max_value = value;
        lrsc_pkg::CFG_PUT_CODE:   put_c = value[7:0];
        lrsc_pkg::CFG_ERASE_CODE: erase_c = value[7:0];
        default: ;
      endcase
    endfunction

    function lrsc_pkg::res_t make_res(logic [1:0] kind, logic [7:0] data, logic val_byte,
                                      logic [2:0] code);
      lrsc_pkg::res_t r;
      logic [7:0] tcode;
      bit rec;
      tcode = hdr[0][55:48];
      rec = (kind != lrsc_pkg::KIND_END);
      r.kind = kind;
      r.data_byte = data;
      r.in_value = val_byte;
      r.is_erase = rec && tcode != put_c && tcode == erase_c;
      r.sequence_res = rec ? hdr[1] : 64'd0;
      r.key_len = rec ? hdr[2][31:0] : 32'd0;
      r.value_len = rec ? hdr[2][63:32] : 32'd0;
      r.status = code;
      r.next_sequence = follow_seq;
      r.last = 1'b0;
      return r;
    endfunction

    function void reject(logic [2:0] code);
      halted = 1'b1;
      sticky = code;
      word_res.push_back(make_res(lrsc_pkg::KIND_VERDICT, 8'd0, 1'b0, code));
    endfunction

    function void close_record();
      phase = IN_HEADER;
      bcount = '0;
      if (hash != hdr[3][31:0]) begin
        reject(lrsc_pkg::ST_CSUM);
        return;
      end
      seen_seq = hdr[1];
      follow_seq = hdr[1] + 64'd1;
      word_res.push_back(make_res(lrsc_pkg::KIND_VERDICT, 8'd0, 1'b0, lrsc_pkg::ST_OK));
    endfunction

    function void header_complete();
      logic [31:0] klen;
      logic [31:0] vlen;
      logic [7:0]  tcode;
      klen = hdr[2][31:0];
      vlen = hdr[2][63:32];
      tcode = hdr[0][55:48];
      if (hdr[0][31:0] != lrsc_pkg::LOG_MAGIC || hdr[0][47:32] != lrsc_pkg::LOG_VERSION) begin
        reject(lrsc_pkg::ST_MAGIC);
        return;
      end
      if (klen > max_key || vlen > max_value) begin
        reject(lrsc_pkg::ST_SIZE);
        return;
      end
      if (hdr[1] <= seen_seq) begin
        reject(lrsc_pkg::ST_ORDER);
        return;
      end
      if (tcode != put_c && tcode != erase_c) begin
        reject(lrsc_pkg::ST_TYPE);
        return;
      end
      key_left = klen;
      value_left = vlen;
      hash = lrsc_pkg::HASH_BASIS;
      if (klen != 32'd0) phase = IN_KEY;
      else if (vlen != 32'd0) phase = IN_VALUE;
      else close_record();
    endfunction

    function void absorb_byte(logic [7:0] b);
      if (halted) return;
      if (phase == IN_HEADER) begin
        hdr[bcount[4:3]][{bcount[2:0], 3'b000} +: 8] = b;
        if (bcount >= lrsc_pkg::HDR_LAST) begin
          bcount = '0;
          header_complete();
        end else begin
          bcount = bcount + 5'd1;
        end
        return;
      end
      hash = (hash ^ {24'd0, b}) * lrsc_pkg::HASH_PRIME;
      if (phase == IN_KEY) begin
        word_res.push_back(make_res(lrsc_pkg::KIND_DATA, b, 1'b0, lrsc_pkg::ST_OK));
        key_left = key_left - 32'd1;
        if (key_left == 32'd0) begin
          if (value_left != 32'd0) phase = IN_VALUE;
          else close_record();
        end
      end else begin
        word_res.push_back(make_res(lrsc_pkg::KIND_DATA, b, 1'b1, lrsc_pkg::ST_OK));
        value_left = value_left - 32'd1;
        if (value_left == 32'd0) close_record();
      end
    endfunction

    function void note_word(lrsc_pkg::in_word_t w);
      lrsc_pkg::res_t r;
      logic [2:0] code;
      word_res.delete();
      if (w.first_byte) restart_parse();
      if (!w.empty_log) absorb_byte(w.log_byte);
      if (w.empty_log || w.end_of_log) begin
        if (halted) code = sticky;
        else if (phase == IN_HEADER && bcount == 5'd0) code = lrsc_pkg::ST_OK;
        else code = lrsc_pkg::ST_PARTIAL;
        word_res.push_back(make_res(lrsc_pkg::KIND_END, 8'd0, 1'b0, code));
      end
      foreach (word_res[i]) begin
        r = word_res[i];
        r.last = (i == word_res.size() - 1);
        expected_q.push_back(r);
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want)
        note_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
                                checked, name, want, got));
    endfunction

    function void check_result(lrsc_pkg::res_t got);
      lrsc_pkg::res_t want;
      checked++;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with none pending (kind %0d status %0d)",
                                checked, got.kind, got.status));
        return;
      end
      want = expected_q.pop_front();
      if (want.kind == lrsc_pkg::KIND_VERDICT) begin
        verdicts++;
        if (want.status != lrsc_pkg::ST_OK) bad_verdicts++;
      end
      cmp_field("kind", 64'(want.kind), 64'(got.kind));
      cmp_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
      cmp_field("in_value", 64'(want.in_value), 64'(got.in_value));
      cmp_field("is_erase", 64'(want.is_erase), 64'(got.is_erase));
      cmp_field("sequence_res", want.sequence_res, got.sequence_res);
      cmp_field("key_len", 64'(want.key_len), 64'(got.key_len));
      cmp_field("value_len", 64'(want.value_len), 64'(got.value_len));
      cmp_field("status", 64'(want.status), 64'(got.status));
      cmp_field("next_sequence", want.next_sequence, got.next_sequence);
      cmp_field("last", 64'(want.last), 64'(got.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  lrsc_in_if  in_ch ();
  lrsc_out_if out_ch ();

  log_record_stream_checker DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  record_scoreboard   sb;
  logic [7:0]         log_q[$];
  logic [63:0]        gen_seq;
  int                 words_sent;
  int                 logs_sent;
  int                 settings_used;
  bit                 calm;
  bit                 hold_req;
  int                 hold_left;
  lrsc_pkg::in_word_t taken_word;
  lrsc_pkg::res_t     seen_res;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_fire) begin
      taken_word.log_byte = in_ch.log_byte;
      taken_word.first_byte = in_ch.first_byte;
      taken_word.end_of_log = in_ch.end_of_log;
      taken_word.empty_log = in_ch.empty_log;
      sb.note_word(taken_word);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_fire) begin
      seen_res.kind = out_ch.kind;
      seen_res.data_byte = out_ch.data_byte;
      seen_res.in_value = out_ch.in_value;
      seen_res.is_erase = out_ch.is_erase;
      seen_res.sequence_res = out_ch.sequence_res;
      seen_res.key_len = out_ch.key_len;
      seen_res.value_len = out_ch.value_len;
      seen_res.status = out_ch.status;
      seen_res.next_sequence = out_ch.next_sequence;
      seen_res.last = out_ch.last;
      sb.check_result(seen_res);
    end
  end

  // hold off the result side for a long stretch when asked
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("tb_log_record_stream_checker: FAIL");
    $finish;
  end

  task automatic send_word(logic [7:0] b, bit first, bit eol, bit empty);
    if (!calm && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.log_byte <= b;
    in_ch.first_byte <= first;
    in_ch.end_of_log <= eol;
    in_ch.empty_log <= empty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_log(bit with_first, log_end_t how);
    int n;
    n = log_q.size();
    for (int i = 0; i < n; i++)
      send_word(log_q[i], with_first && i == 0, how == END_ON_LAST && i == n - 1, 1'b0);
    if (how == END_SEPARATE)
      send_word(8'($urandom), with_first && n == 0, 1'($urandom_range(0, 1)), 1'b1);
    log_q.delete();
    logs_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  function automatic void push_le(logic [63:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) log_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_record(logic [31:0] magic, logic [15:0] ver,
                                     logic [7:0] tcode, logic [63:0] seq,
                                     logic [31:0] klen, logic [31:0] vlen,
                                     bit body, bit bad_csum);
    logic [7:0]  pay[$];
    logic [7:0]  b;
    logic [31:0] h;
    h = lrsc_pkg::HASH_BASIS;
    if (body) begin
      for (int i = 0; i < int'(klen + vlen); i++) begin
        b = 8'($urandom);
        pay.push_back(b);
        h = (h ^ {24'd0, b}) * lrsc_pkg::HASH_PRIME;
      end
    end
    if (bad_csum) h = h ^ (32'd1 << $urandom_range(0, 31));
    push_le(64'(magic), 4);
    push_le(64'(ver), 2);
    log_q.push_back(tcode);
    log_q.push_back(8'($urandom));
    push_le(seq, 8);
    push_le(64'(klen), 4);
    push_le(64'(vlen), 4);
    push_le(64'(h), 4);
    foreach (pay[i]) log_q.push_back(pay[i]);
  endfunction

  function automatic void add_good(logic [31:0] klen, logic [31:0] vlen, bit erase);
    gen_seq = gen_seq + 64'($urandom_range(1, 1000));
    add_record(lrsc_pkg::LOG_MAGIC, lrsc_pkg::LOG_VERSION, erase ? sb.erase_c : sb.put_c,
               gen_seq, klen, vlen, 1'b1, 1'b0);
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.log_byte = '0;
    in_ch.first_byte = 1'b0;
    in_ch.end_of_log = 1'b0;
    in_ch.empty_log = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    gen_seq = '0;
    words_sent = 0;
    logs_sent = 0;
    settings_used = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'($urandom), 1'b1, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1, 1'b1);

    hold_req = 1'b1;
    gen_seq = '0;
    add_good(32'd4, 32'd6, 1'b1);
    add_good(32'd0, 32'd0, 1'b0);
    send_log(1'b1, END_ON_LAST);

    calm = 1'b1;
    add_record(lrsc_pkg::LOG_MAGIC, lrsc_pkg::LOG_VERSION, sb.put_c, gen_seq,
               32'd0, 32'd0, 1'b1, 1'b0);
    repeat (2) log_q.push_back(8'($urandom));
    send_log(1'b0, END_SEPARATE);
    add_record(lrsc_pkg::LOG_MAGIC ^ 32'h0000_0100, lrsc_pkg::LOG_VERSION, sb.put_c, 64'd5,
               32'd0, 32'd0, 1'b1, 1'b0);
    send_log(1'b1, END_ON_LAST);
    calm = 1'b0;

    add_record(lrsc_pkg::LOG_MAGIC, lrsc_pkg::LOG_VERSION, sb.put_c, 64'd3,
               32'd1, 32'd1, 1'b1, 1'b1);
    send_log(1'b1, END_ON_LAST);
    gen_seq = '0;
    add_good(32'd2, 32'd2, 1'b0);
    while (log_q.size() > 10) void'(log_q.pop_back());
    send_log(1'b1, END_ON_LAST);
    drain();

    write_reg(lrsc_pkg::CFG_MAX_KEY, 32'd0);
    write_reg(lrsc_pkg::CFG_MAX_VALUE, 32'd0);
    write_reg(lrsc_pkg::CFG_PUT_CODE, 32'hFF);
    write_reg(lrsc_pkg::CFG_ERASE_CODE, 32'hFF);
    settings_used++;
    add_record(lrsc_pkg::LOG_MAGIC, lrsc_pkg::LOG_VERSION, 8'h00, 64'd1,
               32'd0, 32'd0, 1'b1, 1'b0);
    send_log(1'b1, END_ON_LAST);
    add_record(lrsc_pkg::LOG_MAGIC, lrsc_pkg::LOG_VERSION, 8'hFF, 64'd2,
               32'd1, 32'd0, 1'b0, 1'b0);
    send_log(1'b1, END_ON_LAST);
    drain();

    $display("run covered %0d log words in %0d logs under %0d register settings",
             words_sent, logs_sent, settings_used);
    $display("checked %0d result words: %0d record verdicts, %0d of them errors",
             sb.checked, sb.verdicts, sb.bad_verdicts);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_log_record_stream_checker: PASS");
    end else begin
      $display("tb_log_record_stream_checker: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lrsc_pkg.sv
rtl/lrsc_if.sv
rtl/lrsc_core.sv
rtl/lrsc_res_fifo.sv
rtl/log_record_stream_checker.sv
bench/tb_log_record_stream_checker.sv
